// ===== hw/rtl/bsr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared opcodes, constants and types for the MSB-first bitstream reader.
// ----------------------------------------------------------------------------
package bsr_pkg;

  // Operation codes carried by the opcode field
  localparam logic [3:0] OP_LOAD      = 4'd0;
  localparam logic [3:0] OP_READBITS  = 4'd1;
  localparam logic [3:0] OP_READBIT   = 4'd2;
  localparam logic [3:0] OP_READBYTE  = 4'd3;
  localparam logic [3:0] OP_READ32    = 4'd4;
  localparam logic [3:0] OP_READ16    = 4'd5;
  localparam logic [3:0] OP_ALIGN     = 4'd6;
  localparam logic [3:0] OP_SETOFFSET = 4'd7;
  localparam logic [3:0] OP_SETBITPOS = 4'd8;
  localparam logic [3:0] OP_SKIP      = 4'd9;
  localparam logic [3:0] OP_STEPBYTE  = 4'd10;
  localparam logic [3:0] OP_QUERY     = 4'd11;

  localparam logic [15:0] IDX_MAX     = 16'hFFFF;
  localparam logic [7:0]  BYTE_OOB    = 8'hFF;
  localparam logic [5:0]  MAX_BITS    = 6'd32;
  localparam int          WIN_BYTES   = 5;
  localparam int          WIN_BITS    = WIN_BYTES * 8;

  typedef struct packed {
    logic [15:0] byte_idx;
    logic [2:0]  bit_idx;
  } pos_t;

  typedef struct packed {
    pos_t        pos;
    logic [31:0] value;
    logic        error;
  } alu_res_t;

  function automatic logic is_read_op(input logic [3:0] op);
    return (op == OP_READBITS) || (op == OP_READBIT) || (op == OP_READBYTE) ||
           (op == OP_READ32) || (op == OP_READ16);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/bsr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bsr_alu.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsr_alu
// Evaluates one operation: new read position, value read and error flag,
// from the current position and a five-byte window fetched at byte_idx.
// ----------------------------------------------------------------------------
module bsr_alu (
  input  wire logic [3:0]            op,
  input  wire logic [5:0]            cnt,
  input  wire logic [15:0]           pos_val,
  input  wire bsr_pkg::pos_t         cur,
  input  wire logic [12:0]           len,
  input  wire logic [39:0]           window,
  output bsr_pkg::alu_res_t          res
);
  import bsr_pkg::*;

  logic [18:0] bp;
  logic [18:0] lb;
  logic [18:0] rem;
  logic [5:0]  n_req;
  logic [5:0]  n_eff;
  logic [39:0] shifted;
  logic [31:0] top_bits;
  logic [31:0] bits_val;
  logic [18:0] adv_n;
  logic [18:0] adv_one;
  logic [16:0] idx_ext;
  logic [16:0] len_ext;
  logic        in_bnd;
  logic        fits32;
  logic        fits16;
  logic [15:0] idx_inc;
  logic [16:0] skip_sum;
  logic [15:0] len16;

  assign bp       = {cur.byte_idx, cur.bit_idx};
  assign lb       = {3'b0, len, 3'b0};
  assign rem      = lb - bp;
  assign n_req    = (cnt > MAX_BITS) ? MAX_BITS : cnt;
  // clip to the bits left before the end
  assign n_eff    = ({13'b0, n_req} > rem) ? rem[5:0] : n_req;
  assign shifted  = window << cur.bit_idx;
  assign top_bits = shifted[39:8];
  assign bits_val = top_bits >> (MAX_BITS - n_eff);
  assign adv_n    = bp + {13'b0, n_eff};
  assign adv_one  = bp + 19'd1;

  assign idx_ext  = {1'b0, cur.byte_idx};
  assign len_ext  = {4'b0, len};
  assign len16    = {3'b0, len};
  assign in_bnd   = idx_ext < len_ext;
  assign fits32   = (idx_ext + 17'd3) < len_ext;
  assign fits16   = (idx_ext + 17'd1) < len_ext;
  assign idx_inc  = (cur.byte_idx == IDX_MAX) ? IDX_MAX : cur.byte_idx + 16'd1;
  assign skip_sum = idx_ext + {1'b0, pos_val};

  always_comb begin
    res.pos   = cur;
    res.value = '0;
    res.error = 1'b0;
    case (op)
      OP_READBITS: begin
        if (bp > lb) begin
          res.error = 1'b1;
        end else begin
          res.value        = bits_val;
          res.pos.byte_idx = adv_n[18:3];
          res.pos.bit_idx  = adv_n[2:0];
        end
      end
      OP_READBIT: begin
        if (in_bnd) begin
          res.value        = {31'b0, top_bits[31]};
          res.pos.byte_idx = adv_one[18:3];
          res.pos.bit_idx  = adv_one[2:0];
        end else begin
          res.error = 1'b1;
        end
      end
      OP_READBYTE: begin
        if (in_bnd) begin
          res.value        = {24'b0, window[39:32]};
          res.pos.byte_idx = cur.byte_idx + 16'd1;
        end else begin
          res.error = 1'b1;
        end
      end
      OP_READ32: begin
        if (fits32) begin
          res.value        = window[39:8];
          res.pos.byte_idx = cur.byte_idx + 16'd4;
        end else begin
          res.error = 1'b1;
        end
      end
      OP_READ16: begin
        if (fits16) begin
          res.value        = {16'b0, window[39:24]};
          res.pos.byte_idx = cur.byte_idx + 16'd2;
        end else begin
          res.error = 1'b1;
        end
      end
      OP_ALIGN: begin
        if (cur.bit_idx != 3'd0) begin
          res.pos.byte_idx = idx_inc;
          res.pos.bit_idx  = 3'd0;
        end
      end
      OP_SETOFFSET: begin
        res.pos.byte_idx = (pos_val < len16) ? pos_val : len16;
      end
      OP_SETBITPOS: begin
        res.pos.byte_idx = {3'b0, pos_val[15:3]};
        res.pos.bit_idx  = pos_val[2:0];
      end
      OP_SKIP: begin
        res.pos.byte_idx = skip_sum[16] ? IDX_MAX : skip_sum[15:0];
      end
      OP_STEPBYTE: begin
        if (in_bnd) begin
          res.pos.byte_idx = cur.byte_idx + 16'd1;
        end
      end
      OP_LOAD, OP_QUERY: begin
        res.pos = cur;
      end
      default: begin
        res.pos = cur;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/msb_first_bitstream_reader_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// msb_first_bitstream_reader_top
// MSB-first bit reader over a loaded byte store, one operation per beat.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+----------------------------------------
//   in       | in_valid / in_stall   | opcode, bit_count, position_value,
//            |                       | load_byte
//   out      | out_valid / out_stall | read_value, read_error, bit_position,
//            |                       | bytes_left, current_byte,
//            |                       | current_byte_arith, next_byte_arith
//   cfg      | cfg_valid / cfg_ready | cfg_data -> buffer_length
//
// Steps: a read opcode goes IDLE, FETCH, CALC, PEEK, DONE; any other opcode
//   skips FETCH. The byte store has one read port returning one byte per
//   cycle: a read walks five bytes from the byte index, then every opcode
//   fetches the current and next byte at the new index for the result.
// Reset: clears position, length, sequencer and output valid. The store is
//   not cleared; it must be loaded before it is read.
// Stalls: the result sits in an output register, so the next beat is
//   accepted and worked on while out_stall holds the previous one; the
//   sequencer only waits in its final step for the output register.
// ----------------------------------------------------------------------------
module msb_first_bitstream_reader_top #(
  parameter int STORE_BYTES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input beats
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [3:0]  opcode,
  input  wire logic [5:0]  bit_count,
  input  wire logic [15:0] position_value,
  input  wire logic [7:0]  load_byte,
  // result beats
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      read_value,
  output logic             read_error,
  output logic [18:0]      bit_position,
  output logic [12:0]      bytes_left,
  output logic [7:0]       current_byte,
  output logic [7:0]       current_byte_arith,
  output logic [7:0]       next_byte_arith,
  // length register
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [12:0] cfg_data
);
  import bsr_pkg::*;

  localparam int          AW            = $clog2(STORE_BYTES);
  localparam logic [31:0] STORE_BYTES_W = 32'(STORE_BYTES);
  localparam logic [2:0]  FETCH_LAST    = 3'(WIN_BYTES);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_CALC  = 5'b00100,
    S_PEEK  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t      state;
  logic [2:0]  fcnt;
  logic [1:0]  pcnt;
  logic [3:0]  op;
  logic [5:0]  cnt;
  logic [15:0] pos_val;
  logic [39:0] window;
  pos_t        pos;
  logic [12:0] buffer_length;
  logic [31:0] res_value;
  logic        res_error;
  logic [7:0]  cur_raw;
  logic [7:0]  nxt_raw;

  logic        in_accept;
  logic        out_free;
  logic [12:0] len;
  logic [16:0] idx_ext;
  logic [16:0] len_ext;
  logic        cur_in;
  logic        nxt_in;
  logic        wr_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]  rd_data;
  alu_res_t    alu_res;

  // Effective length never exceeds the store
  assign len = (32'(buffer_length) < STORE_BYTES_W) ? buffer_length : 13'(STORE_BYTES);

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = 1'b1;

  // Load writes straight through on the accept edge; loads past the store drop
  assign wr_en = in_accept && (opcode == OP_LOAD) &&
                 (32'(position_value) < STORE_BYTES_W);

  assign idx_ext = {1'b0, pos.byte_idx};
  assign len_ext = {4'b0, len};
  assign cur_in  = idx_ext < len_ext;
  assign nxt_in  = (idx_ext + 17'd1) < len_ext;

  // Read address: walk the window in FETCH, then current and next in PEEK
  always_comb begin
    case (state)
      S_FETCH: rd_addr = AW'(idx_ext + {14'b0, fcnt});
      S_PEEK:  rd_addr = AW'(idx_ext + {15'b0, pcnt != 2'd0});
      default: rd_addr = AW'(idx_ext);
    endcase
  end

  bsr_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(position_value)),
    .wr_data (load_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  bsr_alu u_alu (
    .op      (op),
    .cnt     (cnt),
    .pos_val (pos_val),
    .cur     (pos),
    .len     (len),
    .window  (window),
    .res     (alu_res)
  );

  // Length register
  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_length <= '0;
    end else if (cfg_valid && cfg_ready) begin
      buffer_length <= cfg_data;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fcnt  <= '0;
      pcnt  <= '0;
      pos   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            fcnt  <= '0;
            state <= is_read_op(opcode) ? S_FETCH : S_CALC;
          end
        end
        S_FETCH: begin
          // data for the address issued last cycle arrives now
          if (fcnt == FETCH_LAST) begin
            state <= S_CALC;
          end
          fcnt <= fcnt + 3'd1;
        end
        S_CALC: begin
          pos   <= alu_res.pos;
          pcnt  <= '0;
          state <= S_PEEK;
        end
        S_PEEK: begin
          pcnt <= pcnt + 2'd1;
          if (pcnt == 2'd2) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath holding registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op      <= opcode;
      cnt     <= bit_count;
      pos_val <= position_value;
    end
    if (state == S_FETCH && fcnt != 3'd0) begin
      window <= {window[31:0], rd_data};
    end
    if (state == S_CALC) begin
      res_value <= alu_res.value;
      res_error <= alu_res.error;
    end
    if (state == S_PEEK && pcnt == 2'd1) begin
      cur_raw <= rd_data;
    end
    if (state == S_PEEK && pcnt == 2'd2) begin
      nxt_raw <= rd_data;
    end
  end

  // Output register: load in DONE when free, drop the beat once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      read_value         <= res_value;
      read_error         <= res_error;
      bit_position       <= {pos.byte_idx, pos.bit_idx};
      bytes_left         <= cur_in ? 13'(len_ext - idx_ext) : 13'd0;
      current_byte       <= cur_in ? cur_raw : 8'd0;
      current_byte_arith <= cur_in ? cur_raw : BYTE_OOB;
      next_byte_arith    <= nxt_in ? nxt_raw : BYTE_OOB;
    end
  end

  // Checks
  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result beat raised outside the final step");

  a_err_zero_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_error |-> read_value == 32'd0)
    else $error("error beat carries a nonzero value");

  a_inbound_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid && bytes_left != 13'd0 |-> current_byte == current_byte_arith)
    else $error("in-bound current byte views disagree");

  a_oob_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid && bytes_left == 13'd0 |->
      current_byte == 8'd0 && current_byte_arith == BYTE_OOB &&
      next_byte_arith == BYTE_OOB)
    else $error("out-of-bound byte views not forced");

  a_fetch_range: assert property (@(posedge clk) disable iff (rst)
    state == S_FETCH |-> fcnt <= FETCH_LAST)
    else $error("window fetch ran past its last byte");

endmodule
`default_nettype wire
